### hdl/mf3_pkg.sv
package mf3_pkg;

   // field widths
   localparam int PIXEL_BITS = 16;
   localparam int SIDE_BITS  = 11;
   localparam int POS_BITS   = 10;
   localparam int VALUE_BITS = 20;
   localparam int FRAC_BITS  = 4;
   localparam int RESET_SIDE = 8;

   // window sums: one column of three, all nine
   localparam int COLSUM_BITS = PIXEL_BITS + 2;
   localparam int SUM_BITS    = PIXEL_BITS + 4;

   // mean = (32*sum + 9) / 18 = (16*sum + 4) / 9, done as a reciprocal multiply
   localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
   localparam int RECIP_SHIFT = DIV_BITS + 4;
   localparam int RECIP_BITS  = RECIP_SHIFT - 3;
   localparam int PROD_BITS   = DIV_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_NINE =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
   localparam logic [DIV_BITS-1:0] ROUND_BIAS = DIV_BITS'(4);

   // result slots of one input pixel, in output order
   localparam int SLOT_CENTER = 0;
   localparam int SLOT_RIGHT  = 1;
   localparam int SLOT_BOTTOM = 2;
   localparam int SLOT_COUNT  = 3;

   typedef logic [SLOT_COUNT-1:0] slot_mask_type;

   typedef struct packed {
      logic [POS_BITS-1:0] row_above;
      logic [POS_BITS-1:0] row_here;
      logic [POS_BITS-1:0] col_left;
      logic [POS_BITS-1:0] col_here;
   } pos_type;

   typedef struct packed {
      slot_mask_type slots;
      logic          interior;
   } flags_type;

   typedef struct packed {
      flags_type             flags;
      pos_type               pos;
      logic [SUM_BITS-1:0]   sum;
      logic [PIXEL_BITS-1:0] center_pix;
      logic [PIXEL_BITS-1:0] right_pix;
      logic [PIXEL_BITS-1:0] bottom_pix;
   } item_type;

   // border pixels pass through in the output fixed point format
   function automatic logic [VALUE_BITS-1:0] border_value(input logic [PIXEL_BITS-1:0] pix);
      return VALUE_BITS'({pix, {FRAC_BITS{1'b0}}});
   endfunction

endpackage

### hdl/mf3_channels.sv
// pixel input channel
interface mf3_req_if;
   logic                            valid;
   logic                            ready;
   logic [mf3_pkg::PIXEL_BITS-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// filtered result channel
interface mf3_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mf3_pkg::POS_BITS-1:0]    out_row;
   logic [mf3_pkg::POS_BITS-1:0]    out_col;
   logic [mf3_pkg::VALUE_BITS-1:0]  mean_value;
   logic                            last_of_run;

   modport source (output valid, output out_row, output out_col, output mean_value,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_row, input out_col, input mean_value,
                   input last_of_run, output ready);
endinterface

// image side register write channel
interface mf3_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mf3_pkg::SIDE_BITS-1:0]   image_side;

   modport source (output valid, output image_side, input ready);
   modport sink   (input valid, input image_side, output ready);
endinterface

### hdl/mf3_line_store.sv
module mf3_line_store #(
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = 10
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [ADDR_BITS-1:0]            rd_addr,
   input  logic [mf3_pkg::PIXEL_BITS-1:0]  wr_pixel,
   input  logic                            shift_en,
   input  logic [ADDR_BITS-1:0]            shift_addr,
   output logic [mf3_pkg::PIXEL_BITS-1:0]  upper_q,
   output logic [mf3_pkg::PIXEL_BITS-1:0]  lower_q
);

   logic [mf3_pkg::PIXEL_BITS-1:0] upper_mem [DEPTH];
   logic [mf3_pkg::PIXEL_BITS-1:0] lower_mem [DEPTH];
   logic [mf3_pkg::PIXEL_BITS-1:0] upper_q_ff;
   logic [mf3_pkg::PIXEL_BITS-1:0] lower_q_ff;

   // read both rows of the column, new pixel replaces the lower row
   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_q_ff         <= upper_mem[rd_addr];
         lower_q_ff         <= lower_mem[rd_addr];
         lower_mem[rd_addr] <= wr_pixel;
      end
   end

   // old lower row moves up once the column leaves the first stage
   always_ff @(posedge clock) begin
      if (shift_en) begin
         upper_mem[shift_addr] <= lower_q_ff;
      end
   end

   assign upper_q = upper_q_ff;
   assign lower_q = lower_q_ff;

endmodule

### hdl/mf3_window.sv
module mf3_window (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [mf3_pkg::PIXEL_BITS-1:0]  pixel,
   input  logic [mf3_pkg::PIXEL_BITS-1:0]  upper_q,
   input  logic [mf3_pkg::PIXEL_BITS-1:0]  lower_q,
   input  mf3_pkg::flags_type              flags,
   input  mf3_pkg::pos_type                pos,
   output mf3_pkg::item_type               item
);

   // the 3x3 window kept as two column sums plus the middle row pixel
   logic [mf3_pkg::COLSUM_BITS-1:0] col1_sum_ff;
   logic [mf3_pkg::COLSUM_BITS-1:0] col2_sum_ff;
   logic [mf3_pkg::PIXEL_BITS-1:0]  mid_ff;
   logic [mf3_pkg::COLSUM_BITS-1:0] col_sum_in;

   // new right column enters the window
   assign col_sum_in = mf3_pkg::COLSUM_BITS'(upper_q) + mf3_pkg::COLSUM_BITS'(lower_q)
                     + mf3_pkg::COLSUM_BITS'(pixel);

   always_ff @(posedge clock) begin
      if (advance) begin
         col1_sum_ff <= col2_sum_ff;
         col2_sum_ff <= col_sum_in;
         mid_ff      <= lower_q;
      end
   end

   // item as seen after the window shift
   always_comb begin
      item.flags      = flags;
      item.pos        = pos;
      item.sum        = mf3_pkg::SUM_BITS'(col1_sum_ff) + mf3_pkg::SUM_BITS'(col2_sum_ff)
                      + mf3_pkg::SUM_BITS'(col_sum_in);
      item.center_pix = mid_ff;
      item.right_pix  = lower_q;
      item.bottom_pix = pixel;
   end

endmodule

### hdl/mf3_result.sv
module mf3_result (
   input  logic               clock,
   input  logic               reset,
   input  logic               offer_valid,
   input  mf3_pkg::item_type  item,
   output logic               item_ready,
   mf3_rsp_if.source          rsp_bus
);

   mf3_pkg::slot_mask_type           pend_ff;
   mf3_pkg::slot_mask_type           pend_in;
   mf3_pkg::item_type                hold_ff;
   logic                             rsp_valid_ff;
   logic [mf3_pkg::POS_BITS-1:0]     rsp_row_ff;
   logic [mf3_pkg::POS_BITS-1:0]     rsp_col_ff;
   logic [mf3_pkg::VALUE_BITS-1:0]   rsp_value_ff;
   logic                             rsp_last_ff;

   logic                             out_free;
   logic                             emit;
   logic                             load;
   mf3_pkg::slot_mask_type           pick;
   mf3_pkg::slot_mask_type           remaining;
   logic [mf3_pkg::POS_BITS-1:0]     pick_row;
   logic [mf3_pkg::POS_BITS-1:0]     pick_col;
   logic [mf3_pkg::VALUE_BITS-1:0]   pick_value;
   logic [mf3_pkg::DIV_BITS-1:0]     dividend;
   logic [mf3_pkg::PROD_BITS-1:0]    product;
   logic [mf3_pkg::VALUE_BITS-1:0]   mean;

   // rounded mean by reciprocal multiply
   assign dividend = (mf3_pkg::DIV_BITS'(hold_ff.sum) << mf3_pkg::FRAC_BITS)
                   + mf3_pkg::ROUND_BIAS;
   assign product  = mf3_pkg::PROD_BITS'(dividend)
                   * mf3_pkg::PROD_BITS'(mf3_pkg::RECIP_NINE);
   assign mean     = product[mf3_pkg::RECIP_SHIFT +: mf3_pkg::VALUE_BITS];

   // pick the earliest pending slot
   always_comb begin
      pick       = '0;
      pick_row   = hold_ff.pos.row_here;
      pick_col   = hold_ff.pos.col_here;
      pick_value = mf3_pkg::border_value(hold_ff.bottom_pix);
      if (pend_ff[mf3_pkg::SLOT_CENTER]) begin
         pick[mf3_pkg::SLOT_CENTER] = 1'b1;
         pick_row   = hold_ff.pos.row_above;
         pick_col   = hold_ff.pos.col_left;
         pick_value = hold_ff.flags.interior ? mean
                                             : mf3_pkg::border_value(hold_ff.center_pix);
      end else if (pend_ff[mf3_pkg::SLOT_RIGHT]) begin
         pick[mf3_pkg::SLOT_RIGHT] = 1'b1;
         pick_row   = hold_ff.pos.row_above;
         pick_col   = hold_ff.pos.col_here;
         pick_value = mf3_pkg::border_value(hold_ff.right_pix);
      end else if (pend_ff[mf3_pkg::SLOT_BOTTOM]) begin
         pick[mf3_pkg::SLOT_BOTTOM] = 1'b1;
      end
   end

   // handshake between the held item and the output register
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign emit       = (pend_ff != '0) && out_free;
   assign remaining  = pend_ff & ~pick;
   assign item_ready = (pend_ff == '0) || (emit && (remaining == '0));
   assign load       = offer_valid && item_ready;

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = item.flags.slots;
      end else if (emit) begin
         pend_in = remaining;
      end
   end

   // held item and its pending slots
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= item;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= pick_row;
         rsp_col_ff   <= pick_col;
         rsp_value_ff <= pick_value;
         rsp_last_ff  <= (remaining == '0);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_row     = rsp_row_ff;
   assign rsp_bus.out_col     = rsp_col_ff;
   assign rsp_bus.mean_value  = rsp_value_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule

### hdl/mean_filter_3x3_border_pass_unit.sv
// Path: a pixel's first result passes the input, held item and output registers in turn.
// Throughput: one pixel per cycle while each pixel causes at most one result and the
// output side does not stall; a pixel that causes two or three results (row ends, last
// row) holds the input until its extra results are sent, since the single output register
// sends one result per cycle.
// Reset: position counters to zero, image side to 8, pipeline empty; line stores kept.
module mean_filter_3x3_border_pass_unit #(
   parameter int MAX_SIDE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   mf3_req_if.sink     req_bus,
   mf3_rsp_if.source   rsp_bus,
   mf3_csr_if.sink     csr_bus
);

   localparam int ADDR_BITS  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int RESET_EFF  = (mf3_pkg::RESET_SIDE > MAX_SIDE) ? MAX_SIDE
                                                                : mf3_pkg::RESET_SIDE;

   logic [SIDE_W-1:0]              side_ff;
   logic [SIDE_W-1:0]              side_in;
   logic [ADDR_BITS-1:0]           row_ff;
   logic [ADDR_BITS-1:0]           row_in;
   logic [ADDR_BITS-1:0]           col_ff;
   logic [ADDR_BITS-1:0]           col_in;

   logic                           s1_valid_ff;
   logic [mf3_pkg::PIXEL_BITS-1:0] s1_pixel_ff;
   mf3_pkg::flags_type             s1_flags_ff;
   mf3_pkg::pos_type               s1_pos_ff;
   logic [ADDR_BITS-1:0]           s1_col_ff;

   logic                           accept;
   logic                           cfg_write;
   logic                           s1_adv;
   logic                           s1_free;
   logic                           s2_ready;
   logic                           last_col;
   logic                           last_row;
   logic [31:0]                    side_req;
   mf3_pkg::flags_type             flags_in;
   mf3_pkg::pos_type               pos_in;
   logic [mf3_pkg::PIXEL_BITS-1:0] upper_q;
   logic [mf3_pkg::PIXEL_BITS-1:0] lower_q;
   mf3_pkg::item_type              item;

   // transaction control
   assign s1_adv        = s1_valid_ff && s2_ready;
   assign s1_free       = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_free && !reset;
   assign csr_bus.ready = !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cfg_write     = csr_bus.valid && csr_bus.ready;

   // position of the incoming pixel
   assign last_col = (SIDE_W'(col_ff) + SIDE_W'(1)) == side_ff;
   assign last_row = (SIDE_W'(row_ff) + SIDE_W'(1)) == side_ff;

   always_comb begin
      flags_in.slots                       = '0;
      flags_in.slots[mf3_pkg::SLOT_CENTER] = (row_ff != '0) && (col_ff != '0);
      flags_in.slots[mf3_pkg::SLOT_RIGHT]  = (row_ff != '0) && last_col;
      flags_in.slots[mf3_pkg::SLOT_BOTTOM] = last_row;
      flags_in.interior = (row_ff > ADDR_BITS'(1)) && (col_ff > ADDR_BITS'(1));
      pos_in.row_here   = mf3_pkg::POS_BITS'(32'(row_ff));
      pos_in.row_above  = mf3_pkg::POS_BITS'(32'(row_ff) - 32'd1);
      pos_in.col_here   = mf3_pkg::POS_BITS'(32'(col_ff));
      pos_in.col_left   = mf3_pkg::POS_BITS'(32'(col_ff) - 32'd1);
   end

   // side clamp and raster counters, a side write restarts the image
   assign side_req = 32'(csr_bus.image_side);

   always_comb begin
      side_in = side_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cfg_write) begin
         if (side_req == 32'd0) begin
            side_in = SIDE_W'(1);
         end else if (side_req > 32'(MAX_SIDE)) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(side_req);
         end
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ADDR_BITS'(1);
         end else begin
            col_in = col_ff + ADDR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(RESET_EFF);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_bus.pixel;
         s1_flags_ff <= flags_in;
         s1_pos_ff   <= pos_in;
         s1_col_ff   <= col_ff;
      end
   end

   mf3_line_store #(
      .DEPTH     (MAX_SIDE),
      .ADDR_BITS (ADDR_BITS)
   ) u_line_store (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (col_ff),
      .wr_pixel   (req_bus.pixel),
      .shift_en   (s1_adv),
      .shift_addr (s1_col_ff),
      .upper_q    (upper_q),
      .lower_q    (lower_q)
   );

   mf3_window u_window (
      .clock   (clock),
      .advance (s1_adv),
      .pixel   (s1_pixel_ff),
      .upper_q (upper_q),
      .lower_q (lower_q),
      .flags   (s1_flags_ff),
      .pos     (s1_pos_ff),
      .item    (item)
   );

   mf3_result u_result (
      .clock       (clock),
      .reset       (reset),
      .offer_valid (s1_valid_ff),
      .item        (item),
      .item_ready  (s2_ready),
      .rsp_bus     (rsp_bus)
   );

   // counters stay inside the image and the side is never zero
   assert property (@(posedge clock) disable iff (reset)
      (side_ff != '0) && (SIDE_W'(row_ff) < side_ff) && (SIDE_W'(col_ff) < side_ff))
      else $error("raster position outside the image");

   // a stalled input register keeps its pixel
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_pixel_ff) && $stable(s1_pos_ff))
      else $error("input register lost a stalled pixel");

   // a side write restarts the raster position
   assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (row_ff == '0) && (col_ff == '0))
      else $error("side write did not restart the image");

endmodule
